@@ rtl/checksummed_frame_builder_core_assert.svh @@
// assertion macros for the frame builder core
`ifndef CHECKSUMMED_FRAME_BUILDER_CORE_ASSERT_SVH
`define CHECKSUMMED_FRAME_BUILDER_CORE_ASSERT_SVH

`ifndef SYNTH
`define CFB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame builder assertion failed");
`define CFB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame builder assertion failed");
`else
`define CFB_ASSERT_IMP(lbl, ante, cons)
`define CFB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/cfb_pkg.sv @@
// shared constants and types for the frame builder
package cfb_pkg;

  localparam int unsigned MAX_PAYLOAD = 59;
  localparam int unsigned HDR_LEN     = 5;
  localparam int unsigned FRAME_ALIGN = 32;
  localparam int unsigned MAX_FRAME   =
      ((HDR_LEN + MAX_PAYLOAD + FRAME_ALIGN - 1) / FRAME_ALIGN) * FRAME_ALIGN;
  localparam int unsigned ALIGN_SH    = $clog2(FRAME_ALIGN);

  localparam int unsigned COUNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned ADDR_W  = $clog2(MAX_PAYLOAD);
  localparam int unsigned IDX_W   = $clog2(MAX_FRAME);

  localparam logic [7:0] START_MARK = 8'h21;
  localparam logic [7:0] PAD_CHAR   = 8'h30;

  // header positions
  localparam int unsigned POS_START  = 0;
  localparam int unsigned POS_LEN_LO = 1;
  localparam int unsigned POS_LEN_HI = 2;
  localparam int unsigned POS_CSUM   = 3;
  localparam int unsigned POS_MID    = 4;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } cfb_state_e;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [7:0]         csum;
    logic [7:0]         mid;
    logic               dropped;
  } cfb_frame_t;

endpackage

@@ rtl/checksummed_frame_builder_core.sv @@
// append is registered; the next item is accepted in the following cycle
// send: the sequencer enters its emit state and registers the first byte,
// then one byte per cycle while output is taken; a frame is 32 or 64 bytes
// input stays blocked until the frame sequencer has loaded the last byte
// reset clears count, sum, drop flag and sequencer; payload ram is not cleared
module checksummed_frame_builder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] message_id_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       frame_last_o,
  output logic       dropped_o
);

  logic [cfb_pkg::COUNT_W-1:0] count_q, count_d;
  logic [7:0]                  sum_q, sum_d;
  logic                        ovf_q, ovf_d;

  logic                        busy;
  logic                        accept;
  logic                        room;
  logic                        we;
  logic                        start;
  cfb_pkg::cfb_frame_t         frame;
  logic                        re;
  logic [cfb_pkg::ADDR_W-1:0]  raddr;
  logic [7:0]                  rdata;

  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;
  assign room       = (count_q < cfb_pkg::COUNT_W'(cfb_pkg::MAX_PAYLOAD));
  assign we         = accept && !cmd_i && room;
  assign start      = accept && cmd_i;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    ovf_d   = ovf_q;
    if (start) begin
      count_d = '0;
      sum_d   = '0;
      ovf_d   = 1'b0;
    end else if (accept) begin
      if (room) begin
        count_d = count_q + cfb_pkg::COUNT_W'(1);
        sum_d   = sum_q + data_byte_i;
      end else begin
        ovf_d = 1'b1;
      end
    end
    frame.count   = count_q;
    frame.csum    = ~sum_q;
    frame.mid     = message_id_i;
    frame.dropped = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      ovf_q   <= ovf_d;
    end
  end

  cfb_ram #(
    .WIDTH (8),
    .DEPTH (cfb_pkg::MAX_PAYLOAD)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[cfb_pkg::ADDR_W-1:0]),
    .wdata_i (data_byte_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cfb_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .frame_i      (frame),
    .busy_o       (busy),
    .re_o         (re),
    .raddr_o      (raddr),
    .rdata_i      (rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .frame_last_o (frame_last_o),
    .dropped_o    (dropped_o)
  );

endmodule

@@ rtl/cfb_ram.sv @@
// generic simple dual-port ram with registered read
module cfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 59,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cfb_emit.sv @@
// frame sequencer: walks the frame and prefetches payload from the ram
module cfb_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  cfb_pkg::cfb_frame_t        frame_i,
  output logic                       busy_o,
  output logic                       re_o,
  output logic [cfb_pkg::ADDR_W-1:0] raddr_o,
  input  logic [7:0]                 rdata_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       frame_last_o,
  output logic                       dropped_o
);

  localparam int unsigned IW = cfb_pkg::IDX_W;

  cfb_pkg::cfb_state_e state_q, state_d;
  cfb_pkg::cfb_frame_t info_q;
  logic [IW-1:0]       idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;
  logic                out_drop_q;

  logic          adv;
  logic          is_last;
  logic [IW:0]   total;
  logic [IW:0]   last_idx;
  logic [IW-1:0] pay_ofs;
  logic [IW-1:0] pre_ofs;
  logic [IW-1:0] cnt_ext;
  logic [7:0]    sel_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfb_pkg::ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      info_q <= frame_i;
    end
    if (adv) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
      out_drop_q <= info_q.dropped;
    end
  end

  always_comb begin
    cnt_ext  = IW'(info_q.count);
    // frame length rounded up to the alignment
    total    = (((IW+1)'(cfb_pkg::HDR_LEN) + (IW+1)'(info_q.count)
                 + (IW+1)'(cfb_pkg::FRAME_ALIGN - 1)) >> cfb_pkg::ALIGN_SH)
               << cfb_pkg::ALIGN_SH;
    last_idx = total - (IW+1)'(1);
    pay_ofs  = idx_q - IW'(cfb_pkg::HDR_LEN);
    pre_ofs  = idx_q - IW'(cfb_pkg::HDR_LEN - 1);
    adv      = (state_q == cfb_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);
    is_last  = ({1'b0, idx_q} == last_idx);

    case (idx_q)
      IW'(cfb_pkg::POS_START):  sel_byte = cfb_pkg::START_MARK;
      IW'(cfb_pkg::POS_LEN_LO): sel_byte = 8'(info_q.count);
      IW'(cfb_pkg::POS_LEN_HI): sel_byte = 8'h00;
      IW'(cfb_pkg::POS_CSUM):   sel_byte = info_q.csum;
      IW'(cfb_pkg::POS_MID):    sel_byte = info_q.mid;
      default:                  sel_byte = (pay_ofs < cnt_ext) ? rdata_i : cfb_pkg::PAD_CHAR;
    endcase

    // fetch the payload byte for the next position one step ahead
    re_o    = adv && (idx_q >= IW'(cfb_pkg::HDR_LEN - 1)) && (pre_ofs < cnt_ext);
    raddr_o = pre_ofs[cfb_pkg::ADDR_W-1:0];

    out_byte_d  = sel_byte;
    out_last_d  = is_last;
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      cfb_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = cfb_pkg::ST_EMIT;
          idx_d   = '0;
        end
      end
      cfb_pkg::ST_EMIT: begin
        if (adv) begin
          out_valid_d = 1'b1;
          idx_d       = idx_q + IW'(1);
          if (is_last) begin
            state_d = cfb_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = cfb_pkg::ST_IDLE;
    endcase
  end

  assign busy_o       = (state_q == cfb_pkg::ST_EMIT);
  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign frame_last_o = out_last_q;
  assign dropped_o    = out_drop_q;

`include "checksummed_frame_builder_core_assert.svh"

  `CFB_ASSERT_IMP(a_start_idle, start_i, state_q == cfb_pkg::ST_IDLE)
  `CFB_ASSERT_IMP(a_read_in_range, re_o, adv && (pre_ofs < cnt_ext))
  `CFB_ASSERT_NXT(a_last_ends_frame, adv && is_last, state_q == cfb_pkg::ST_IDLE && out_valid_q)
  `CFB_ASSERT_NXT(a_load_sets_valid, adv, out_valid_q)

endmodule
